>>> design/xfs_pkg.sv
// Shared types and constants for the XOR16-checked frame segmenter.
// No dependencies; used by the controller, the datapath and the top level.
`default_nettype none

package xfs_pkg;

    // Default payload store depth
    localparam int DEFAULT_MAX_PAYLOAD = 124;

    // Configuration port
    localparam int CFG_INDEX_W = 4;
    localparam int CFG_DATA_W  = 8;
    localparam logic [CFG_INDEX_W-1:0] REG_FRAME_TYPE    = 4'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_PAYLOAD_LIMIT = 4'd1;

    // Register reset values
    localparam logic [7:0] FRAME_TYPE_RESET    = 8'd48;
    localparam logic [6:0] PAYLOAD_LIMIT_RESET = 7'd124;

    // End-of-packet characters
    localparam logic [7:0] EOP_YES = 8'h31;
    localparam logic [7:0] EOP_NO  = 8'h30;

    // Fixed header byte positions within a frame
    localparam int POS_LEN     = 0;
    localparam int POS_SEQ_LO  = 1;
    localparam int POS_SEQ_HI  = 2;
    localparam int POS_TYPE    = 3;
    localparam int POS_EOP     = 4;
    localparam int POS_PAYLOAD = 5;

    // Controller states
    typedef enum logic [0:0] {
        ST_COLLECT,
        ST_DRAIN
    } state_t;

    // Controller to datapath
    typedef struct packed {
        logic take_input;
        logic drain_active;
    } cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic frame_trigger;
        logic drain_done;
    } status_t;

endpackage

`default_nettype wire

>>> design/xfs_ram.sv
// Generic simple dual-port RAM: one write port, one registered read port.
// No dependencies.
`default_nettype none

module xfs_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 124,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             clk,
    input  wire logic             we,
    input  wire logic [AW-1:0]    waddr,
    input  wire logic [WIDTH-1:0] wdata,
    input  wire logic             re,
    input  wire logic [AW-1:0]    raddr,
    output logic      [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // Registered read, holds when not enabled
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire

>>> design/xfs_datapath.sv
// Datapath: config registers, payload store, checksum, frame byte sequencer,
// word packer and output register. Depends on xfs_pkg and xfs_ram.
`default_nettype none

module xfs_datapath #(
    parameter int MAX_PAYLOAD = xfs_pkg::DEFAULT_MAX_PAYLOAD
) (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire xfs_pkg::cmd_t                  cmd,
    output xfs_pkg::status_t                    status,
    // config
    input  wire logic                           cfg_valid,
    input  wire logic [xfs_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  wire logic [xfs_pkg::CFG_DATA_W-1:0]  cfg_data,
    // input item
    input  wire logic                           in_valid,
    input  wire logic [7:0]                     data_byte,
    input  wire logic                           packet_last,
    // output item
    output logic                                out_valid,
    input  wire logic                           out_stall,
    output logic [31:0]                         frame_word,
    output logic [2:0]                          byte_count,
    output logic                                frame_end
);

    localparam int FW = $clog2(MAX_PAYLOAD + 1);
    localparam int JW = $clog2(MAX_PAYLOAD + 7);
    localparam int AW = (MAX_PAYLOAD > 1) ? $clog2(MAX_PAYLOAD) : 1;
    localparam int CW = (FW > 7) ? FW : 7;

    // Config registers
    logic [7:0] type_reg;
    logic [6:0] limit_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            type_reg  <= xfs_pkg::FRAME_TYPE_RESET;
            limit_reg <= xfs_pkg::PAYLOAD_LIMIT_RESET;
        end
        else if (cfg_valid)
        begin
            if (cfg_index == xfs_pkg::REG_FRAME_TYPE)
            begin
                type_reg <= cfg_data;
            end
            else if (cfg_index == xfs_pkg::REG_PAYLOAD_LIMIT)
            begin
                limit_reg <= cfg_data[6:0];
            end
        end
    end

    // Effective limit: zero acts as one, saturate at store depth
    logic [CW-1:0] limit_ext;
    logic [CW-1:0] eff_limit;

    always_comb
    begin
        limit_ext = CW'(limit_reg);
        eff_limit = limit_ext;
        if (limit_ext == '0)
        begin
            eff_limit = CW'(1);
        end
        else if (limit_ext > CW'(MAX_PAYLOAD))
        begin
            eff_limit = CW'(MAX_PAYLOAD);
        end
    end

    // Collect state
    logic [FW-1:0] fill_reg, fill_next;
    logic [15:0]   xor_reg, xor_next;
    logic [15:0]   seq_reg, seq_next;
    logic          eop_reg;
    logic          in_take;
    logic          drain_done;

    assign in_take = cmd.take_input && in_valid;

    always_comb
    begin
        fill_next = fill_reg;
        xor_next  = xor_reg;
        seq_next  = seq_reg;
        if (in_take)
        begin
            fill_next = fill_reg + FW'(1);
            if (fill_reg[0])
            begin
                xor_next = xor_reg ^ {data_byte, 8'h00};
            end
            else
            begin
                xor_next = xor_reg ^ {8'h00, data_byte};
            end
        end
        else if (drain_done)
        begin
            fill_next = '0;
            xor_next  = '0;
            seq_next  = seq_reg + 16'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fill_reg <= '0;
            xor_reg  <= '0;
            seq_reg  <= '0;
        end
        else
        begin
            fill_reg <= fill_next;
            xor_reg  <= xor_next;
            seq_reg  <= seq_next;
        end
    end

    // End-of-packet mark of the frame being drained
    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            eop_reg <= packet_last;
        end
    end

    assign status.frame_trigger = in_take &&
        (packet_last || (CW'(fill_next) >= eff_limit));

    // Frame byte sequencer
    logic [JW-1:0] j_reg;
    logic [JW-1:0] fill_j;
    logic [JW-1:0] ck_lo_idx;
    logic [JW-1:0] last_idx;
    logic [15:0]   ck;
    logic [8:0]    len_sum;
    logic [7:0]    eop_char;
    logic [7:0]    cur_byte;
    logic [7:0]    rd_data;
    logic          rd_en;
    logic [AW-1:0] rd_addr;
    logic [JW-1:0] rd_off;
    logic          advance;
    logic          word_done;

    assign fill_j    = JW'(fill_reg);
    assign ck_lo_idx = fill_j + JW'(xfs_pkg::POS_PAYLOAD);
    assign last_idx  = fill_j + JW'(xfs_pkg::POS_PAYLOAD + 1);
    assign len_sum   = 9'(fill_reg) + 9'd6;
    assign eop_char  = eop_reg ? xfs_pkg::EOP_YES : xfs_pkg::EOP_NO;
    assign ck        = seq_reg ^ {eop_char, type_reg} ^ xor_reg;

    // Pick the frame byte at position j
    always_comb
    begin
        priority if (j_reg == JW'(xfs_pkg::POS_LEN))
        begin
            cur_byte = len_sum[7:0];
        end
        else if (j_reg == JW'(xfs_pkg::POS_SEQ_LO))
        begin
            cur_byte = seq_reg[7:0];
        end
        else if (j_reg == JW'(xfs_pkg::POS_SEQ_HI))
        begin
            cur_byte = seq_reg[15:8];
        end
        else if (j_reg == JW'(xfs_pkg::POS_TYPE))
        begin
            cur_byte = type_reg;
        end
        else if (j_reg == JW'(xfs_pkg::POS_EOP))
        begin
            cur_byte = eop_char;
        end
        else if (j_reg == ck_lo_idx)
        begin
            cur_byte = ck[7:0];
        end
        else if (j_reg == last_idx)
        begin
            cur_byte = ck[15:8];
        end
        else
        begin
            cur_byte = rd_data;
        end
    end

    // Word packer
    logic [31:0] acc_reg;
    logic [1:0]  pos_reg;
    logic [31:0] acc_merged;
    logic        out_free;

    assign acc_merged = acc_reg | (32'(cur_byte) << {pos_reg, 3'b000});
    assign word_done  = (pos_reg == 2'd3) || (j_reg == last_idx);
    assign out_free   = !out_valid || !out_stall;
    assign advance    = cmd.drain_active && (!word_done || out_free);
    assign drain_done = advance && (j_reg == last_idx);
    assign status.drain_done = drain_done;

    // Issue the read at the position before the payload byte's slot
    assign rd_off  = j_reg - JW'(xfs_pkg::POS_EOP);
    assign rd_addr = rd_off[AW-1:0];
    assign rd_en   = advance && (j_reg >= JW'(xfs_pkg::POS_EOP)) &&
                     (j_reg < (fill_j + JW'(xfs_pkg::POS_EOP)));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            j_reg   <= '0;
            pos_reg <= '0;
            acc_reg <= '0;
        end
        else if (advance)
        begin
            if (drain_done)
            begin
                j_reg <= '0;
            end
            else
            begin
                j_reg <= j_reg + JW'(1);
            end
            if (word_done)
            begin
                pos_reg <= '0;
                acc_reg <= '0;
            end
            else
            begin
                pos_reg <= pos_reg + 2'd1;
                acc_reg <= acc_merged;
            end
        end
    end

    // Output register
    logic        out_valid_reg;
    logic [31:0] word_reg;
    logic [2:0]  count_reg;
    logic        end_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance && word_done)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance && word_done)
        begin
            word_reg  <= acc_merged;
            count_reg <= {1'b0, pos_reg} + 3'd1;
            end_reg   <= (j_reg == last_idx);
        end
    end

    assign out_valid  = out_valid_reg;
    assign frame_word = word_reg;
    assign byte_count = count_reg;
    assign frame_end  = end_reg;

    // Payload store
    xfs_ram #(
        .WIDTH(8),
        .DEPTH(MAX_PAYLOAD)
    ) u_store (
        .clk   (clk),
        .we    (in_take),
        .waddr (fill_reg[AW-1:0]),
        .wdata (data_byte),
        .re    (rd_en),
        .raddr (rd_addr),
        .rdata (rd_data)
    );

endmodule

`default_nettype wire

>>> design/xfs_ctrl.sv
// Controller: collects payload bytes, then sequences one frame drain.
// Depends on xfs_pkg.
`default_nettype none

module xfs_ctrl (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire xfs_pkg::status_t status,
    output xfs_pkg::cmd_t         cmd
);

    xfs_pkg::state_t state_reg, state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= xfs_pkg::ST_COLLECT;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            xfs_pkg::ST_COLLECT:
            begin
                if (status.frame_trigger)
                begin
                    state_next = xfs_pkg::ST_DRAIN;
                end
            end
            xfs_pkg::ST_DRAIN:
            begin
                if (status.drain_done)
                begin
                    state_next = xfs_pkg::ST_COLLECT;
                end
            end
        endcase
    end

    // Commands
    always_comb
    begin
        cmd = '0;
        unique case (state_reg)
            xfs_pkg::ST_COLLECT: cmd.take_input   = 1'b1;
            xfs_pkg::ST_DRAIN:   cmd.drain_active = 1'b1;
        endcase
    end

endmodule

`default_nettype wire

>>> design/xor16_checked_frame_segmenter.sv
// Top level of the XOR16-checked frame segmenter.
// Depends on xfs_pkg, xfs_ctrl, xfs_datapath (and xfs_ram below it).
//
// Packet bytes are taken one per cycle into a byte-wide payload store until
// the payload limit is reached or a byte flagged packet_last arrives. The
// frame (length, sequence low/high, type, end-of-packet char, payload, XOR16
// checksum) is then sent as 32-bit words, lowest byte first, with byte_count
// and frame_end; a frame of n payload bytes holds n + 7 bytes. The drain
// walks the frame one byte per cycle, unless the output stalls, through the
// store's single read port; input is stalled during the drain. The final
// word may still wait at the output while the next packet's bytes come in.
// Configuration (index 0 frame type, index 1 payload limit) is always ready.
`default_nettype none

module xor16_checked_frame_segmenter #(
    parameter int MAX_PAYLOAD = xfs_pkg::DEFAULT_MAX_PAYLOAD
) (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    // config write
    input  wire logic                            cfg_valid,
    output logic                                 cfg_ready,
    input  wire logic [xfs_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  wire logic [xfs_pkg::CFG_DATA_W-1:0]  cfg_data,
    // input items
    input  wire logic                            in_valid,
    output logic                                 in_stall,
    input  wire logic [7:0]                      data_byte,
    input  wire logic                            packet_last,
    // output items
    output logic                                 out_valid,
    input  wire logic                            out_stall,
    output logic [31:0]                          frame_word,
    output logic [2:0]                           byte_count,
    output logic                                 frame_end
);

    xfs_pkg::cmd_t    cmd;
    xfs_pkg::status_t status;

    assign cfg_ready = 1'b1;
    assign in_stall  = !cmd.take_input;

    xfs_ctrl u_ctrl (
        .clk    (clk),
        .rst_n  (rst_n),
        .status (status),
        .cmd    (cmd)
    );

    xfs_datapath #(
        .MAX_PAYLOAD(MAX_PAYLOAD)
    ) u_datapath (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .status      (status),
        .cfg_valid   (cfg_valid),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .in_valid    (in_valid),
        .data_byte   (data_byte),
        .packet_last (packet_last),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .frame_word  (frame_word),
        .byte_count  (byte_count),
        .frame_end   (frame_end)
    );

endmodule

`default_nettype wire
